// ===== rtl/core/tbp_pkg.sv =====
// Package for the two-bit branch predictor table: widths, codes and the
// request/response structs that pass between the top level and the slot table.
// No dependencies.
package tbp_pkg;

  localparam int unsigned AddrW = 32;
  localparam int unsigned CntW  = 2;
  localparam int unsigned EvW   = 3;
  localparam int unsigned StatW = 32;

  // counter values
  localparam logic [CntW-1:0] CntMax   = 2'd3;
  localparam logic [CntW-1:0] CntAlloc = 2'd1;
  localparam logic [CntW-1:0] CntZero  = 2'd0;

  typedef enum logic [EvW-1:0] {
    EV_FIRST     = 3'd0,
    EV_UNTRACKED = 3'd1,
    EV_CORRECT   = 3'd2,
    EV_WRONG     = 3'd3,
    EV_ALLOC     = 3'd4
  } event_e;

  // one judged branch, handed to the table in the cycle it commits
  typedef struct packed {
    logic             valid;
    logic [AddrW-1:0] prev;
    logic             taken;
  } tbl_req_t;

  // outcome of the lookup, from the table state before the update
  typedef struct packed {
    event_e           ev;
    logic             pred;
    logic [CntW-1:0]  cnt_after;
    logic             evicted;
    logic [AddrW-1:0] ev_addr;
  } tbl_rsp_t;

endpackage

// ===== rtl/core/tbp_if.sv =====
// Valid/ready stream interfaces for the predictor's input and result channels.
// Depends on tbp_pkg for field widths.
interface tbp_in_if;
  logic                      valid;
  logic                      ready;
  logic [tbp_pkg::AddrW-1:0] addr;

  modport source (output valid, output addr, input ready);
  modport sink   (input valid, input addr, output ready);
endinterface

interface tbp_out_if;
  logic                      valid;
  logic                      ready;
  logic [tbp_pkg::EvW-1:0]   event_res;
  logic                      predicted_taken;
  logic [tbp_pkg::CntW-1:0]  counter_after;
  logic                      evicted;
  logic [tbp_pkg::AddrW-1:0] evicted_addr;
  logic [tbp_pkg::StatW-1:0] right_total;
  logic [tbp_pkg::StatW-1:0] wrong_total;
  logic [tbp_pkg::StatW-1:0] miss_total;
  logic [tbp_pkg::StatW-1:0] hit_total;

  modport source (output valid, output event_res, output predicted_taken,
                  output counter_after, output evicted, output evicted_addr,
                  output right_total, output wrong_total, output miss_total,
                  output hit_total, input ready);
  modport sink   (input valid, input event_res, input predicted_taken,
                  input counter_after, input evicted, input evicted_addr,
                  input right_total, input wrong_total, input miss_total,
                  input hit_total, output ready);
endinterface

// ===== rtl/core/two_bit_branch_predictor_table.sv =====
// Two-bit saturating-counter branch predictor with a fully associative table.
// Flow: an address transfer loads the input register; the result register
// loads from it once the result side can take it, and the result is offered.
// Throughput: one address per cycle while the result side keeps up; a held
// result stalls the input once the input register is also full.
// Reset empties the table, forgets the last address and clears all totals.
module two_bit_branch_predictor_table #(
  parameter int unsigned TABLE_ENTRIES = 8,
  parameter int unsigned INSTR_STRIDE  = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  tbp_in_if.sink           in_i,
  tbp_out_if.source        out_o
);

  localparam logic [tbp_pkg::AddrW-1:0] StrideC = tbp_pkg::AddrW'(INSTR_STRIDE);

  function automatic logic [tbp_pkg::StatW-1:0] sat_inc(input logic [tbp_pkg::StatW-1:0] v);
    return (&v) ? v : v + tbp_pkg::StatW'(1);
  endfunction

  logic                       s1_valid_q;
  logic [tbp_pkg::AddrW-1:0]  s1_addr_q;
  logic                       last_valid_q;
  logic [tbp_pkg::AddrW-1:0]  last_addr_q;
  logic                       out_valid_q;
  tbp_pkg::event_e            ev_q, ev_d;
  logic                       pred_q;
  logic [tbp_pkg::CntW-1:0]   cnt_q;
  logic                       evd_q;
  logic [tbp_pkg::AddrW-1:0]  evd_addr_q;
  logic [tbp_pkg::StatW-1:0]  right_q, wrong_q, miss_q, hit_q;

  logic              advance;
  logic              in_ready;
  tbp_pkg::tbl_req_t req;
  tbp_pkg::tbl_rsp_t rsp;

  assign advance  = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_ready = !s1_valid_q || advance;
  assign in_i.ready = in_ready;

  assign req.valid = advance && last_valid_q;
  assign req.prev  = last_addr_q;
  assign req.taken = (s1_addr_q - last_addr_q) != StrideC;

  tbp_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_table (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  assign ev_d = last_valid_q ? rsp.ev : tbp_pkg::EV_FIRST;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      last_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      right_q      <= '0;
      wrong_q      <= '0;
      miss_q       <= '0;
      hit_q        <= '0;
    end else begin
      if (in_ready) s1_valid_q <= in_i.valid;
      if (advance) begin
        last_valid_q <= 1'b1;
        out_valid_q  <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (req.valid) begin
        if (rsp.ev == tbp_pkg::EV_CORRECT) right_q <= sat_inc(right_q);
        if (rsp.ev == tbp_pkg::EV_WRONG)   wrong_q <= sat_inc(wrong_q);
        if (rsp.ev == tbp_pkg::EV_ALLOC)   miss_q  <= sat_inc(miss_q);
        if (req.taken && (rsp.ev == tbp_pkg::EV_CORRECT || rsp.ev == tbp_pkg::EV_WRONG)) begin
          hit_q <= sat_inc(hit_q);
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) s1_addr_q <= in_i.addr;
    if (advance) begin
      last_addr_q <= s1_addr_q;
      ev_q        <= ev_d;
      pred_q      <= last_valid_q && rsp.pred;
      cnt_q       <= last_valid_q ? rsp.cnt_after : tbp_pkg::CntZero;
      evd_q       <= last_valid_q && rsp.evicted;
      evd_addr_q  <= last_valid_q ? rsp.ev_addr : '0;
    end
  end

  // totals track the result register: they only move when it is reloaded
  assign out_o.valid           = out_valid_q;
  assign out_o.event_res       = ev_q;
  assign out_o.predicted_taken = pred_q;
  assign out_o.counter_after   = cnt_q;
  assign out_o.evicted         = evd_q;
  assign out_o.evicted_addr    = evd_addr_q;
  assign out_o.right_total     = right_q;
  assign out_o.wrong_total     = wrong_q;
  assign out_o.miss_total      = miss_q;
  assign out_o.hit_total       = hit_q;

  // an eviction only comes with a scored fall-through or an allocation
  a_evict_event : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && evd_q) |->
      (ev_q == tbp_pkg::EV_CORRECT || ev_q == tbp_pkg::EV_WRONG || ev_q == tbp_pkg::EV_ALLOC))
    else $error("eviction reported with a non-table event");

  // a single transfer scores at most one way
  a_one_score : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((right_q != $past(right_q)) && (wrong_q != $past(wrong_q))))
    else $error("right and wrong totals moved together");

  // totals only change when a result is loaded
  a_totals_on_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!advance) |=> ($stable(right_q) && $stable(wrong_q) && $stable(miss_q) && $stable(hit_q)))
    else $error("totals changed without a transfer into the result register");

endmodule

// ===== rtl/core/tbp_victim.sv =====
// Replacement choice: binary compare tree over all slots picking the lowest
// counter, then the lowest address in signed order. Depends on tbp_pkg.
module tbp_victim #(
  parameter int unsigned TABLE_ENTRIES = 8
) (
  input  logic [TABLE_ENTRIES-1:0]                     slot_valid_i,
  input  logic [TABLE_ENTRIES-1:0][tbp_pkg::AddrW-1:0] slot_addr_i,
  input  logic [TABLE_ENTRIES-1:0][tbp_pkg::CntW-1:0]  slot_cnt_i,
  output logic [((TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1)-1:0] victim_o
);

  localparam int unsigned IdxW   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned Leaves = 2 ** IdxW;
  localparam int unsigned Nodes  = 2 * Leaves - 1;
  localparam int unsigned KeyW   = tbp_pkg::CntW + tbp_pkg::AddrW;

  logic [Nodes-1:0]           node_vld;
  logic [Nodes-1:0][KeyW-1:0] node_key;
  logic [Nodes-1:0][IdxW-1:0] node_idx;

  // leaves sit at heap positions Leaves-1 .. Nodes-1
  for (genvar i = 0; i < Leaves; i++) begin : g_leaf
    if (i < TABLE_ENTRIES) begin : g_used
      // flipping the sign bit makes unsigned order equal signed order
      assign node_vld[Leaves-1+i] = slot_valid_i[i];
      assign node_key[Leaves-1+i] = {slot_cnt_i[i], ~slot_addr_i[i][tbp_pkg::AddrW-1],
                                     slot_addr_i[i][tbp_pkg::AddrW-2:0]};
    end else begin : g_pad
      assign node_vld[Leaves-1+i] = 1'b0;
      assign node_key[Leaves-1+i] = '0;
    end
    assign node_idx[Leaves-1+i] = IdxW'(i);
  end

  // left child holds the lower slot numbers, so it wins a tie
  for (genvar n = 0; n < Leaves - 1; n++) begin : g_node
    logic take_left;
    assign take_left = node_vld[2*n+1] &&
                       (!node_vld[2*n+2] || (node_key[2*n+1] <= node_key[2*n+2]));
    assign node_vld[n] = node_vld[2*n+1] || node_vld[2*n+2];
    assign node_key[n] = take_left ? node_key[2*n+1] : node_key[2*n+2];
    assign node_idx[n] = take_left ? node_idx[2*n+1] : node_idx[2*n+2];
  end

  assign victim_o = node_idx[0];

endmodule

// ===== rtl/core/tbp_table.sv =====
// Fully associative slot table: address match, free-slot and victim choice,
// counter update. Depends on tbp_pkg and tbp_victim.
module tbp_table #(
  parameter int unsigned TABLE_ENTRIES = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tbp_pkg::tbl_req_t req_i,
  output tbp_pkg::tbl_rsp_t rsp_o
);

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic [TABLE_ENTRIES-1:0]                     slot_valid_q, slot_valid_d;
  logic [TABLE_ENTRIES-1:0][tbp_pkg::AddrW-1:0] slot_addr_q;
  logic [TABLE_ENTRIES-1:0][tbp_pkg::CntW-1:0]  slot_cnt_q;

  logic [TABLE_ENTRIES-1:0] hit_vec, free_vec, free_oh;
  logic [IdxW-1:0]          hit_idx, free_idx, victim_idx, alloc_idx;
  logic                     hit, any_free;
  logic [tbp_pkg::CntW-1:0] hit_cnt;
  logic                     wr_en;
  logic [IdxW-1:0]          wr_idx;
  logic [tbp_pkg::CntW-1:0] wr_cnt;

  tbp_victim #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_victim (
    .slot_valid_i(slot_valid_q),
    .slot_addr_i (slot_addr_q),
    .slot_cnt_i  (slot_cnt_q),
    .victim_o    (victim_idx)
  );

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      hit_vec[i] = slot_valid_q[i] && (slot_addr_q[i] == req_i.prev);
      if (hit_vec[i]) hit_idx = hit_idx | IdxW'(i);
    end
    free_vec = ~slot_valid_q;
    // isolate the lowest free slot
    free_oh  = free_vec & (~free_vec + TABLE_ENTRIES'(1));
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (free_oh[i]) free_idx = free_idx | IdxW'(i);
    end
    hit       = |hit_vec;
    any_free  = |free_vec;
    alloc_idx = any_free ? free_idx : victim_idx;
    hit_cnt   = slot_cnt_q[hit_idx];
  end

  // outcome and write-back
  always_comb begin
    rsp_o        = '0;
    rsp_o.ev     = tbp_pkg::EV_UNTRACKED;
    slot_valid_d = slot_valid_q;
    wr_en        = 1'b0;
    wr_idx       = hit_idx;
    wr_cnt       = hit_cnt;
    if (hit) begin
      rsp_o.pred = hit_cnt[tbp_pkg::CntW-1];
      rsp_o.ev   = (rsp_o.pred == req_i.taken) ? tbp_pkg::EV_CORRECT : tbp_pkg::EV_WRONG;
      if (req_i.taken) begin
        wr_en  = 1'b1;
        wr_cnt = (hit_cnt == tbp_pkg::CntMax) ? hit_cnt : hit_cnt + tbp_pkg::CntW'(1);
      end else if (hit_cnt == tbp_pkg::CntZero) begin
        slot_valid_d[hit_idx] = 1'b0;
        rsp_o.evicted         = 1'b1;
        rsp_o.ev_addr         = slot_addr_q[hit_idx];
      end else begin
        wr_en  = 1'b1;
        wr_cnt = hit_cnt - tbp_pkg::CntW'(1);
      end
      rsp_o.cnt_after = wr_en ? wr_cnt : tbp_pkg::CntZero;
    end else if (req_i.taken) begin
      rsp_o.ev                = tbp_pkg::EV_ALLOC;
      rsp_o.cnt_after         = tbp_pkg::CntAlloc;
      rsp_o.evicted           = !any_free;
      rsp_o.ev_addr           = any_free ? '0 : slot_addr_q[victim_idx];
      slot_valid_d[alloc_idx] = 1'b1;
      wr_en                   = 1'b1;
      wr_idx                  = alloc_idx;
      wr_cnt                  = tbp_pkg::CntAlloc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
    end else if (req_i.valid) begin
      slot_valid_q <= slot_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && wr_en) begin
      slot_cnt_q[wr_idx] <= wr_cnt;
      if (!hit) slot_addr_q[wr_idx] <= req_i.prev;
    end
  end

endmodule

// ===== bench/two_bit_branch_predictor_table_tb.sv =====
// Self-checking bench for two_bit_branch_predictor_table: directed branch
// cases, then random program-like address walks with stalls on both sides.
// Depends on tbp_pkg, tbp_if and the predictor RTL.
module two_bit_branch_predictor_table_tb;
  import tbp_pkg::*;

  localparam int unsigned TABLE_SLOTS = 8;
  localparam logic [AddrW-1:0] STRIDE = 32'd4;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 60;
  localparam int NUM_SITES = 12;

  typedef struct packed {
    event_e            ev;
    logic              pred;
    logic [CntW-1:0]   cnt;
    logic              evd;
    logic [AddrW-1:0]  ev_addr;
    logic [StatW-1:0]  right;
    logic [StatW-1:0]  wrong;
    logic [StatW-1:0]  miss;
    logic [StatW-1:0]  hit;
  } branch_outcome_t;

  class predictor_board;
    logic [AddrW-1:0] prev_pc;
    bit               prev_seen;
    bit               live [TABLE_SLOTS];
    logic [AddrW-1:0] site [TABLE_SLOTS];
    logic [CntW-1:0]  ctr  [TABLE_SLOTS];
    logic [StatW-1:0] n_right, n_wrong, n_miss, n_hit;
    branch_outcome_t  pending [$];
    int               mismatches;
    int               checked;
    int               ev_seen [5];
    int               evictions;

    function new();
      prev_pc   = '0;
      prev_seen = 1'b0;
      foreach (live[i]) begin
        live[i] = 1'b0;
        site[i] = '0;
        ctr[i]  = '0;
      end
      n_right = '0;
      n_wrong = '0;
      n_miss  = '0;
      n_hit   = '0;
      mismatches = 0;
      checked    = 0;
      evictions  = 0;
      foreach (ev_seen[i]) ev_seen[i] = 0;
    endfunction

    function logic [StatW-1:0] sat_bump(logic [StatW-1:0] v);
      return (v == '1) ? v : v + 1'b1;
    endfunction

    // work out the outcome of one accepted address and queue it
    function void note_addr(logic [AddrW-1:0] pc);
      branch_outcome_t o;
      logic [AddrW-1:0] delta;
      int hit_at, slot;
      bit taken;
      logic [CntW-1:0] c;
      o = '0;
      o.ev = EV_FIRST;
      if (!prev_seen) begin
        prev_seen = 1'b1;
      end else begin
        delta = pc - prev_pc;
        taken = (delta != STRIDE);
        hit_at = -1;
        for (int i = 0; i < TABLE_SLOTS; i++)
          if (hit_at < 0 && live[i] && site[i] == prev_pc) hit_at = i;
        if (taken && hit_at >= 0) begin
          c = ctr[hit_at];
          o.pred = (c >= 2'd2);
          if (o.pred) begin
            o.ev = EV_CORRECT;
            n_right = sat_bump(n_right);
          end else begin
            o.ev = EV_WRONG;
            n_wrong = sat_bump(n_wrong);
          end
          if (c != CntMax) c = c + 1'b1;
          ctr[hit_at] = c;
          o.cnt = c;
          n_hit = sat_bump(n_hit);
        end else if (taken) begin
          slot = -1;
          for (int i = 0; i < TABLE_SLOTS; i++)
            if (slot < 0 && !live[i]) slot = i;
          if (slot < 0) begin
            // table full: lowest counter goes, ties to the lowest signed address
            slot = 0;
            for (int i = 1; i < TABLE_SLOTS; i++)
              if (ctr[i] < ctr[slot] ||
                  (ctr[i] == ctr[slot] && $signed(site[i]) < $signed(site[slot])))
                slot = i;
            o.evd = 1'b1;
            o.ev_addr = site[slot];
          end
          live[slot] = 1'b1;
          site[slot] = prev_pc;
          ctr[slot]  = CntAlloc;
          o.ev  = EV_ALLOC;
          o.cnt = CntAlloc;
          n_miss = sat_bump(n_miss);
        end else if (hit_at >= 0) begin
          c = ctr[hit_at];
          o.pred = (c >= 2'd2);
          if (o.pred) begin
            o.ev = EV_WRONG;
            n_wrong = sat_bump(n_wrong);
          end else begin
            o.ev = EV_CORRECT;
            n_right = sat_bump(n_right);
          end
          if (c == CntZero) begin
            live[hit_at] = 1'b0;
            o.evd = 1'b1;
            o.ev_addr = site[hit_at];
          end else begin
            c = c - 1'b1;
            ctr[hit_at] = c;
            o.cnt = c;
          end
        end else begin
          o.ev = EV_UNTRACKED;
        end
      end
      prev_pc = pc;
      o.right = n_right;
      o.wrong = n_wrong;
      o.miss  = n_miss;
      o.hit   = n_hit;
      pending.push_back(o);
    endfunction

    function void check_outcome(branch_outcome_t got);
      branch_outcome_t want;
      checked++;
      if (pending.size() == 0) begin
        if (mismatches < 10)
          $display("[%0t] result with nothing expected: ev=%0d", $realtime, got.ev);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (want.ev <= EV_ALLOC) ev_seen[want.ev]++;
      if (want.evd) evictions++;
      if (got.ev != want.ev || got.pred != want.pred || got.cnt != want.cnt ||
          got.evd != want.evd || got.ev_addr != want.ev_addr ||
          got.right != want.right || got.wrong != want.wrong ||
          got.miss != want.miss || got.hit != want.hit) begin
        if (mismatches < 10) begin
          $display("[%0t] mismatch on result %0d", $realtime, checked);
          $display("  exp ev=%0d pred=%0b cnt=%0d evd=%0b ev_addr=%h r=%0d w=%0d m=%0d h=%0d",
                   want.ev, want.pred, want.cnt, want.evd, want.ev_addr,
                   want.right, want.wrong, want.miss, want.hit);
          $display("  got ev=%0d pred=%0b cnt=%0d evd=%0b ev_addr=%h r=%0d w=%0d m=%0d h=%0d",
                   got.ev, got.pred, got.cnt, got.evd, got.ev_addr,
                   got.right, got.wrong, got.miss, got.hit);
        end
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  tbp_in_if  in_if ();
  tbp_out_if out_if ();

  two_bit_branch_predictor_table #(
    .TABLE_ENTRIES (TABLE_SLOTS),
    .INSTR_STRIDE  (4)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  predictor_board board = new();
  bit idle_on  = 1'b1;
  bit hold_req = 1'b0;
  int cycles   = 0;

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("two_bit_branch_predictor_table test failed");
      $finish;
    end
  end

  // transfer monitor: results are checked before the new address is noted
  always @(posedge clk_i) begin
    branch_outcome_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.ev      = event_e'(out_if.event_res);
      got.pred    = out_if.predicted_taken;
      got.cnt     = out_if.counter_after;
      got.evd     = out_if.evicted;
      got.ev_addr = out_if.evicted_addr;
      got.right   = out_if.right_total;
      got.wrong   = out_if.wrong_total;
      got.miss    = out_if.miss_total;
      got.hit     = out_if.hit_total;
      board.check_outcome(got);
    end
    if (rst_ni && in_if.valid && in_if.ready) board.note_addr(in_if.addr);
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
    end
  end

  task automatic send_addr(input logic [AddrW-1:0] a);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.addr  <= a;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // Walks a small synthetic program: branch sites with biased directions and
  // short fall-through runs into the next site. More sites than table slots,
  // so allocation keeps evicting; a few wild jumps add noise.
  task automatic run_program(input int n_items);
    logic [AddrW-1:0] sites [NUM_SITES];
    logic [AddrW-1:0] targets [NUM_SITES];
    int bias [NUM_SITES];
    logic [AddrW-1:0] pc;
    int k;
    pc = '0;
    for (int i = 0; i < n_items; i++) begin
      if (i % 300 == 0) begin
        for (int j = 0; j < NUM_SITES; j++) sites[j] = $urandom;
        for (int j = 0; j < NUM_SITES; j++) begin
          targets[j] = sites[$urandom_range(0, NUM_SITES - 1)] - 4 * $urandom_range(0, 3);
          case ($urandom_range(0, 2))
            0: bias[j] = 5;
            1: bias[j] = 50;
            default: bias[j] = 95;
          endcase
        end
        pc = targets[0];
      end
      send_addr(pc);
      k = -1;
      for (int j = 0; j < NUM_SITES; j++)
        if (k < 0 && sites[j] == pc) k = j;
      if (k >= 0) begin
        pc = ($urandom_range(0, 99) < bias[k]) ? targets[k] : pc + STRIDE;
      end else begin
        case ($urandom_range(0, 99)) inside
          [0:2]:   pc = $urandom;
          [3:22]:  pc = targets[$urandom_range(0, NUM_SITES - 1)];
          default: pc = pc + STRIDE;
        endcase
      end
    end
  endtask

  initial begin
    logic [AddrW-1:0] directed_pcs [$];
    directed_pcs = '{
      32'h0000_0000, 32'h0000_0004, 32'h0000_0100, 32'h0000_0104, 32'h0000_0004,
      32'h0000_0100, 32'h0000_0104, 32'h0000_0004, 32'h0000_0100, 32'h0000_0104,
      32'h0000_0004, 32'h0000_0008, 32'h0000_000C, 32'hFFFF_FFFF, 32'h0000_0003,
      32'hFFFF_FFFF, 32'h0000_0003, 32'h8000_0000, 32'h7FFF_FFFC, 32'hFFFF_FFF0,
      32'h0000_0010, 32'hDEAD_BEEC, 32'h1234_5678, 32'h5555_5554, 32'hAAAA_AAA8
    };
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.addr   = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first address, fall-through and wrap, hits both ways, all-ones address,
    // then a full table with signed tie-breaks
    foreach (directed_pcs[i]) send_addr(directed_pcs[i]);

    hold_req = 1'b1;
    run_program(1200);
    idle_on = 1'b0;
    run_program(200);
    in_if.valid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("checked %0d results: %0d first, %0d untracked, %0d right, %0d wrong,",
             board.checked, board.ev_seen[EV_FIRST], board.ev_seen[EV_UNTRACKED],
             board.ev_seen[EV_CORRECT], board.ev_seen[EV_WRONG]);
    $display("%0d allocations, %0d evictions or removals, %0d mismatches",
             board.ev_seen[EV_ALLOC], board.evictions, board.mismatches);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("two_bit_branch_predictor_table test passed");
    end else begin
      $display("two_bit_branch_predictor_table test failed");
    end
    $finish;
  end

endmodule
